// File: src/nfarm_pkg.sv
// Shared types, codes and defaults for the automaton matcher.
`default_nettype none

package nfarm_pkg;

  localparam int unsigned NUM_STATES_DEF      = 64;
  localparam int unsigned NUM_TRANSITIONS_DEF = 256;
  localparam int unsigned LENGTH_BITS_DEF     = 16;

  localparam int unsigned STATE_W    = 6;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned TCOUNT_W   = 9;
  localparam int unsigned LEN_OUT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 9;

  // Transition event codes
  localparam logic [KIND_W-1:0] EV_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] EV_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] EV_ANY   = 2'd2;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TEXT  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_STATE = 8'd1;

  typedef struct packed {
    logic [STATE_W-1:0] from_st;
    logic [STATE_W-1:0] to_st;
    logic [KIND_W-1:0]  kind;
    logic [SYM_W-1:0]   sym;
  } trans_t;

  typedef struct packed {
    logic   vld;   // ent holds a table entry of the running pass
    logic   done;  // pass finished, all entries delivered
    trans_t ent;
  } scan_stat_t;

endpackage

`default_nettype wire

// File: src/nfarm_table_scan.sv
// Transition table memory with a pass sequencer that streams entries in index order.
`default_nettype none

module nfarm_table_scan import nfarm_pkg::*; #(
  parameter int unsigned NUM_TRANSITIONS = NUM_TRANSITIONS_DEF
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      wr_en_i,
  input  wire  [$clog2(NUM_TRANSITIONS)-1:0]       wr_addr_i,
  input  trans_t                                   wr_data_i,
  input  wire                                      start_i,
  input  wire  [$clog2(NUM_TRANSITIONS+1)-1:0]     lim_i,
  output scan_stat_t                               stat_o
);

  localparam int unsigned AW = $clog2(NUM_TRANSITIONS);
  localparam int unsigned CW = $clog2(NUM_TRANSITIONS + 1);

  trans_t          mem_q [NUM_TRANSITIONS];
  trans_t          rd_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic            rvld_q;
  logic            rd_en;
  logic            done;

  assign rd_en = busy_q && (cnt_q < lim_i);
  assign done  = busy_q && !rd_en && !rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_q <= mem_q[cnt_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rvld_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rvld_q <= 1'b0;
    end else if (busy_q) begin
      rvld_q <= rd_en;
      if (rd_en) begin
        cnt_q <= CW'(cnt_q + 1'b1);
      end
      if (done) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign stat_o.vld  = rvld_q;
  assign stat_o.done = done;
  assign stat_o.ent  = rd_q;

endmodule

`default_nettype wire

// File: src/nfa_regex_matcher.sv
// Top level of the automaton matcher: item decode, state-set update and result register.
`default_nettype none

// Runs a nondeterministic automaton held in a loaded transition table over a text
// stream. A word with tuser = 0 writes one table entry without a result. A word
// with tuser = 1 feeds one text character and gives one result word. All
// per-character work is paced by the table memory, read one entry a cycle; a pass
// scans the first transition_count entries, limited to NUM_TRANSITIONS. A character
// needs one move pass plus closure passes over empty transitions, repeated until a
// pass adds no state (at least one), and a character that starts a text also runs
// the closure passes of the start state first. A character that starts no text and
// finds the active set already empty runs no pass. Each result waits until the
// previous one has left the output side. A new word is taken while the previous
// result still waits on the output side.
module nfa_regex_matcher import nfarm_pkg::*; #(
  parameter int unsigned NUM_STATES      = NUM_STATES_DEF,
  parameter int unsigned NUM_TRANSITIONS = NUM_TRANSITIONS_DEF,
  parameter int unsigned LENGTH_BITS     = LENGTH_BITS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // entry_index, from_state, to_state, event_kind, symbol, text_start
  input  wire  [31:0]           s_axis_tdata,
  // cmd
  input  wire                   s_axis_tuser,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // accept_now, set_alive, found, match_length
  output logic [23:0]           m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned StW = $clog2(NUM_STATES);
  localparam int unsigned AW  = $clog2(NUM_TRANSITIONS);
  localparam int unsigned CW  = $clog2(NUM_TRANSITIONS + 1);
  localparam int unsigned OW  = 3 + LEN_OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_STEP,
    ST_CLOSE,
    ST_DONE
  } state_e;

  function automatic logic set_has(logic [NUM_STATES-1:0] s, logic [STATE_W-1:0] st);
    logic r;
    r = 1'b0;
    if (32'(st) < NUM_STATES) begin
      r = s[StW'(st)];
    end
    return r;
  endfunction

  function automatic logic st_ok(logic [STATE_W-1:0] st);
    return 32'(st) < NUM_STATES;
  endfunction

  // Input word fields
  logic [IDX_W-1:0]   in_idx;
  trans_t             in_ent;
  logic               in_start;
  logic               in_acc;
  logic               tab_wr;

  assign in_idx         = s_axis_tdata[7:0];
  assign in_ent.from_st = s_axis_tdata[13:8];
  assign in_ent.to_st   = s_axis_tdata[19:14];
  assign in_ent.kind    = s_axis_tdata[21:20];
  assign in_ent.sym     = s_axis_tdata[29:22];
  assign in_start       = s_axis_tdata[30];

  state_e                 state_q, state_d;
  logic [NUM_STATES-1:0]  cur_q, cur_d;
  logic [NUM_STATES-1:0]  nxt_q, nxt_d;
  logic [SYM_W-1:0]       chr_q, chr_d;
  logic                   live_q, live_d;
  logic                   chg_q, chg_d;
  logic                   go_q, go_d;
  logic [LENGTH_BITS-1:0] chars_q, chars_d;
  logic [LENGTH_BITS-1:0] best_q, best_d;
  logic                   found_q, found_d;
  logic [TCOUNT_W-1:0]    tcount_q, tcount_d;
  logic [STATE_W-1:0]     acc_q, acc_d;
  logic                   out_vld_q, out_vld_d;
  logic [OW-1:0]          out_q, out_d;

  logic [CW-1:0]          lim;
  scan_stat_t             scan;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign tab_wr        = in_acc && (s_axis_tuser == CMD_WRITE)
                         && (32'(in_idx) < NUM_TRANSITIONS);
  assign cfg_ready_o   = 1'b1;

  assign lim = (32'(tcount_q) > NUM_TRANSITIONS) ? CW'(NUM_TRANSITIONS) : CW'(tcount_q);

  nfarm_table_scan #(
    .NUM_TRANSITIONS(NUM_TRANSITIONS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tab_wr),
    .wr_addr_i (AW'(in_idx)),
    .wr_data_i (in_ent),
    .start_i   (go_q),
    .lim_i     (lim),
    .stat_o    (scan)
  );

  always_comb begin
    logic [LENGTH_BITS-1:0] chars_new;
    logic                   acc_hit;
    logic                   ev_hit;
    logic                   close_hit;

    state_d   = state_q;
    cur_d     = cur_q;
    nxt_d     = nxt_q;
    chr_d     = chr_q;
    live_d    = live_q;
    chg_d     = chg_q;
    go_d      = 1'b0;
    chars_d   = chars_q;
    best_d    = best_q;
    found_d   = found_q;
    tcount_d  = tcount_q;
    acc_d     = acc_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;

    chars_new = (chars_q != '1) ? LENGTH_BITS'(chars_q + 1'b1) : chars_q;
    acc_hit   = set_has(nxt_q, acc_q);
    ev_hit    = ((scan.ent.kind == EV_CHAR) && (scan.ent.sym == chr_q))
                || (scan.ent.kind == EV_ANY);
    close_hit = scan.vld && (scan.ent.kind == EV_EMPTY)
                && set_has(nxt_q, scan.ent.from_st) && st_ok(scan.ent.to_st)
                && !set_has(nxt_q, scan.ent.to_st);

    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TRANS_COUNT:  tcount_d = cfg_data_i;
        REG_ACCEPT_STATE: acc_d    = cfg_data_i[STATE_W-1:0];
        default: ;
      endcase
    end

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == CMD_TEXT)) begin
          chr_d = in_ent.sym;
          if (in_start) begin
            nxt_d    = '0;
            nxt_d[0] = 1'b1;
            chars_d  = '0;
            best_d   = '0;
            found_d  = 1'b0;
            chg_d    = 1'b0;
            go_d     = 1'b1;
            state_d  = ST_START;
          end else if (|cur_q) begin
            nxt_d   = '0;
            live_d  = 1'b1;
            go_d    = 1'b1;
            state_d = ST_STEP;
          end else begin
            nxt_d   = cur_q;
            live_d  = 1'b0;
            state_d = ST_DONE;
          end
        end
      end
      ST_START: begin
        if (close_hit) begin
          nxt_d[StW'(scan.ent.to_st)] = 1'b1;
          chg_d = 1'b1;
        end
        if (scan.done) begin
          if (chg_q) begin
            chg_d = 1'b0;
            go_d  = 1'b1;
          end else begin
            // start closure settled: it becomes the set the character moves
            cur_d = nxt_q;
            if (|nxt_q) begin
              nxt_d   = '0;
              live_d  = 1'b1;
              go_d    = 1'b1;
              state_d = ST_STEP;
            end else begin
              live_d  = 1'b0;
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_STEP: begin
        if (scan.vld && ev_hit && set_has(cur_q, scan.ent.from_st)
            && st_ok(scan.ent.to_st)) begin
          nxt_d[StW'(scan.ent.to_st)] = 1'b1;
        end
        if (scan.done) begin
          chg_d   = 1'b0;
          go_d    = 1'b1;
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (close_hit) begin
          nxt_d[StW'(scan.ent.to_st)] = 1'b1;
          chg_d = 1'b1;
        end
        if (scan.done) begin
          if (chg_q) begin
            chg_d = 1'b0;
            go_d  = 1'b1;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          cur_d = nxt_q;
          if (live_q) begin
            chars_d = chars_new;
            if (acc_hit) begin
              found_d = 1'b1;
              best_d  = chars_new;
            end
          end
          out_vld_d = 1'b1;
          out_d     = {LEN_OUT_W'(best_d), found_d, |nxt_q, acc_hit};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      nxt_q     <= '0;
      chr_q     <= '0;
      live_q    <= 1'b0;
      chg_q     <= 1'b0;
      go_q      <= 1'b0;
      chars_q   <= '0;
      best_q    <= '0;
      found_q   <= 1'b0;
      tcount_q  <= '0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      nxt_q     <= nxt_d;
      chr_q     <= chr_d;
      live_q    <= live_d;
      chg_q     <= chg_d;
      go_q      <= go_d;
      chars_q   <= chars_d;
      best_q    <= best_d;
      found_q   <= found_d;
      tcount_q  <= tcount_d;
      acc_q     <= acc_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(24 - OW)'(0), out_q};

  // a match is only recorded after at least one consumed character
  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (best_q != '0))
    else $error("found flag set with zero match length");

  a_best_le_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q <= chars_q)
    else $error("match length exceeds consumed characters");

  a_accept_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q[0]) |-> out_q[1])
    else $error("accept reported on an empty set");

  a_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> !scan.vld)
    else $error("table entry delivered outside a pass");

endmodule

`default_nettype wire

// File: tb/nfarm_checker.sv
// Checker for the automaton matcher: watches all channels, predicts each result word and compares.
`default_nettype none

module nfarm_checker import nfarm_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire  [31:0]           s_tdata_i,
  input  wire                   s_tuser_i,
  input  wire                   s_tvalid_i,
  input  wire                   s_tready_i,
  input  wire  [23:0]           m_tdata_i,
  input  wire                   m_tvalid_i,
  input  wire                   m_tready_i,
  input  wire                   cfg_valid_i,
  input  wire                   cfg_ready_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_count_o
);

  localparam int unsigned NSTATES = NUM_STATES_DEF;
  localparam int unsigned NTRANS  = NUM_TRANSITIONS_DEF;

  typedef struct packed {
    logic                 accept_now;
    logic                 set_alive;
    logic                 found;
    logic [LEN_OUT_W-1:0] match_len;
  } match_rpt_t;

  trans_t                table_mem [NTRANS];
  logic [TCOUNT_W-1:0]   trans_count;
  logic [STATE_W-1:0]    accept_st;
  logic [NSTATES-1:0]    active;
  logic [LEN_OUT_W-1:0]  consumed;
  logic [LEN_OUT_W-1:0]  best_len;
  logic                  found_q;
  match_rpt_t            pending_results [$];
  int                    errs;
  match_rpt_t            got_rpt;
  match_rpt_t            want_rpt;
  match_rpt_t            new_rpt;

  function automatic int unsigned scan_limit();
    return (trans_count > NTRANS) ? NTRANS : int'(trans_count);
  endfunction

  // Repeat passes over the empty-event entries until no state is added.
  function automatic logic [NSTATES-1:0] close_over_empty(input logic [NSTATES-1:0] s);
    logic [NSTATES-1:0] cur;
    bit                 grew;
    int unsigned        lim;
    int unsigned        i;
    cur  = s;
    lim  = scan_limit();
    grew = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (i = 0; i < lim; i++) begin
        if (table_mem[i].kind == EV_EMPTY && cur[table_mem[i].from_st] &&
            !cur[table_mem[i].to_st]) begin
          cur[table_mem[i].to_st] = 1'b1;
          grew = 1'b1;
        end
      end
    end
    return cur;
  endfunction

  task automatic run_character(input logic [SYM_W-1:0] ch, input logic restart,
                               output match_rpt_t rpt);
    logic [NSTATES-1:0] nxt;
    int unsigned        lim;
    int unsigned        i;
    logic               hit;
    if (restart) begin
      active    = '0;
      active[0] = 1'b1;
      active    = close_over_empty(active);
      consumed  = '0;
      best_len  = '0;
      found_q   = 1'b0;
    end
    // a dead set ignores the character entirely
    if (active != '0) begin
      nxt = '0;
      lim = scan_limit();
      for (i = 0; i < lim; i++) begin
        hit = (table_mem[i].kind == EV_CHAR && table_mem[i].sym == ch) ||
              table_mem[i].kind == EV_ANY;
        if (hit && active[table_mem[i].from_st]) nxt[table_mem[i].to_st] = 1'b1;
      end
      active = close_over_empty(nxt);
      if (consumed != '1) consumed = consumed + 1'b1;
      if (active[accept_st]) begin
        found_q  = 1'b1;
        best_len = consumed;
      end
    end
    rpt.accept_now = active[accept_st];
    rpt.set_alive  = |active;
    rpt.found      = found_q;
    rpt.match_len  = best_len;
  endtask

  task automatic note_failure(input string msg);
    if (errs < 10) $display("[%0t] %s", $time, msg);
    errs++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_count = '0;
      accept_st   = '0;
      active      = '0;
      consumed    = '0;
      best_len    = '0;
      found_q     = 1'b0;
      errs        = 0;
      pending_results.delete();
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      // a result word always belongs to an earlier character, so retire it first
      if (m_tvalid_i && m_tready_i) begin
        got_rpt.accept_now = m_tdata_i[0];
        got_rpt.set_alive  = m_tdata_i[1];
        got_rpt.found      = m_tdata_i[2];
        got_rpt.match_len  = m_tdata_i[18:3];
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result word with nothing expected: %h", m_tdata_i));
        end else begin
          want_rpt = pending_results.pop_front();
          if (got_rpt.accept_now !== want_rpt.accept_now ||
              got_rpt.set_alive !== want_rpt.set_alive ||
              got_rpt.found !== want_rpt.found ||
              got_rpt.match_len !== want_rpt.match_len) begin
            note_failure($sformatf(
              "mismatch: expected accept=%0d alive=%0d found=%0d len=%0d, got %0d %0d %0d %0d",
              want_rpt.accept_now, want_rpt.set_alive, want_rpt.found, want_rpt.match_len,
              got_rpt.accept_now, got_rpt.set_alive, got_rpt.found, got_rpt.match_len));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TRANS_COUNT:  trans_count = cfg_data_i[TCOUNT_W-1:0];
          REG_ACCEPT_STATE: accept_st   = cfg_data_i[STATE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == CMD_WRITE) begin
          table_mem[s_tdata_i[7:0]] = '{from_st: s_tdata_i[13:8], to_st: s_tdata_i[19:14],
                                        kind: s_tdata_i[21:20], sym: s_tdata_i[29:22]};
        end else begin
          run_character(s_tdata_i[29:22], s_tdata_i[30], new_rpt);
          pending_results.insert(pending_results.size(), new_rpt);
        end
      end
      fail_count_o    <= errs;
      pending_count_o <= pending_results.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench top for the automaton matcher: clock, reset, stimulus, back-pressure and verdict.
`default_nettype none

module tb;
  import nfarm_pkg::*;

  localparam logic [KIND_W-1:0] EV_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [31:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  wire  [23:0]           m_tdata;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_cnt;
  int                    pend_cnt;

  bit                    quiet = 1'b0;
  bit                    hold_req = 1'b0;
  int                    hold_left = 0;
  logic [SYM_W-1:0]      alphabet [4];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  nfa_regex_matcher i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  nfarm_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_tdata_i       (s_tdata),
    .s_tuser_i       (s_tuser),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .m_tdata_i       (m_tdata),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_cnt),
    .pending_count_o (pend_cnt)
  );

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return EV_CHAR;
    if (r < 7) return EV_EMPTY;
    if (r < 9) return EV_ANY;
    return EV_UNUSED;
  endfunction

  function automatic logic [SYM_W-1:0] pick_sym();
    if ($urandom_range(0, 9) == 0) return SYM_W'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, 3)];
  endfunction

  // tdata: entry_index, from_state, to_state, event_kind, symbol, text_start, pad
  function automatic logic [31:0] pack_word(input logic [IDX_W-1:0] idx,
                                            input logic [STATE_W-1:0] from_st,
                                            input logic [STATE_W-1:0] to_st,
                                            input logic [KIND_W-1:0] kind,
                                            input logic [SYM_W-1:0] sym, input logic start);
    return {1'b0, start, sym, kind, to_st, from_st, idx};
  endfunction

  task automatic send_word(input logic user, input logic [31:0] data);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = user;
    s_tdata  = data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic put_entry(input logic [IDX_W-1:0] idx, input logic [STATE_W-1:0] from_st,
                           input logic [STATE_W-1:0] to_st, input logic [KIND_W-1:0] kind,
                           input logic [SYM_W-1:0] sym);
    send_word(CMD_WRITE, pack_word(idx, from_st, to_st, kind, sym, 1'($urandom_range(0, 1))));
  endtask

  // unused fields of a text word carry random bits
  task automatic put_char(input logic [SYM_W-1:0] sym, input logic start);
    send_word(CMD_TEXT, pack_word(IDX_W'($urandom_range(0, 255)),
                                  STATE_W'($urandom_range(0, 63)),
                                  STATE_W'($urandom_range(0, 63)),
                                  KIND_W'($urandom_range(0, 3)), sym, start));
  endtask

  // states mostly below nst so that the active set stays alive
  task automatic put_rand_entry(input int idx, input int nst);
    logic [STATE_W-1:0] to_st;
    to_st = ($urandom_range(0, 19) == 0) ? STATE_W'($urandom_range(0, 63))
                                         : STATE_W'($urandom_range(0, nst - 1));
    put_entry(IDX_W'(idx), STATE_W'($urandom_range(0, nst - 1)), to_st, pick_kind(),
              pick_sym());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every expected word, then let a trailing table write finish
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pend_cnt != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_phase(input int n_items);
    int tc, lim, nst, sent, len, k, i, r, budget;
    tc = $urandom_range(0, 19);
    if (tc == 0) tc = 256;
    else if (tc == 1) tc = 511;
    else if (tc == 2) tc = 0;
    else tc = $urandom_range(1, 16);
    lim = (tc > 256) ? 256 : tc;
    // full-table scans are slow, keep those phases short
    budget = (lim > 16) ? 8 : n_items;
    nst = $urandom_range(2, 8);
    for (i = 0; i < 4; i++) alphabet[i] = SYM_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) alphabet[0] = 8'h00;
    if ($urandom_range(0, 3) == 0) alphabet[1] = 8'hff;
    quiet = ($urandom_range(0, 4) == 0);
    if (lim > 16) begin
      for (i = 0; i < 4; i++) put_rand_entry($urandom_range(0, lim - 1), nst);
    end else begin
      for (i = 0; i < lim; i++) put_rand_entry(i, nst);
    end
    settle();
    write_reg(REG_TRANS_COUNT, tc);
    write_reg(REG_ACCEPT_STATE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                            : $urandom_range(0, nst - 1));
    sent = 0;
    while (sent < budget) begin
      len = (lim > 16) ? $urandom_range(1, 3) : $urandom_range(1, 12);
      for (k = 0; k < len && sent < budget; k++) begin
        r = $urandom_range(0, 19);
        if (r == 0 && lim > 0) put_rand_entry($urandom_range(0, lim - 1), nst);
        else if (r == 1) put_char(pick_sym(), 1'($urandom_range(0, 1)));
        else put_char(pick_sym(), k == 0);
        sent++;
      end
    end
    settle();
    quiet = 1'b0;
  endtask

  // receiver: random ready pattern, plus one long hold on request
  initial begin
    int burst;
    bit held;
    burst = 0;
    held  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        hold_left = 400;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        m_tready  = 1'b0;
        hold_left = hold_left - 1;
      end else if (burst > 0) begin
        burst = burst - 1;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        m_tready = 1'b1;
        burst    = $urandom_range(0, 12);
      end else begin
        m_tready = 1'b0;
        burst    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      end
    end
  end

  initial begin
    #40000000;
    $display("tb failed");
    $finish;
  end

  initial begin
    int total, n, i;
    for (i = 0; i < 4; i++) alphabet[i] = SYM_W'($urandom_range(0, 255));
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // dead set straight out of reset, then a start on an empty table
    put_char(8'h61, 1'b0);
    put_char(8'hff, 1'b1);

    // load every entry so no scan ever touches an unwritten one
    for (i = 0; i < 256; i++)
      put_entry(IDX_W'(i), STATE_W'($urandom_range(0, 63)), STATE_W'($urandom_range(0, 63)),
                pick_kind(), SYM_W'($urandom_range(0, 255)));

    // small automaton: a .* 0xff reaches 63; start closure 0 -> 5, 5 --0x00--> 63
    put_entry(8'd0, 6'd0, 6'd1, EV_CHAR, 8'h61);
    put_entry(8'd1, 6'd1, 6'd2, EV_EMPTY, 8'h00);
    put_entry(8'd2, 6'd2, 6'd2, EV_ANY, 8'h33);
    put_entry(8'd3, 6'd2, 6'd3, EV_CHAR, 8'hff);
    put_entry(8'd4, 6'd3, 6'd63, EV_EMPTY, 8'h00);
    put_entry(8'd5, 6'd0, 6'd5, EV_EMPTY, 8'h00);
    put_entry(8'd6, 6'd5, 6'd63, EV_CHAR, 8'h00);
    put_entry(8'd7, 6'd0, 6'd6, EV_UNUSED, 8'h61);
    settle();
    write_reg(REG_TRANS_COUNT, 8);
    write_reg(REG_ACCEPT_STATE, 63);
    put_char(8'h61, 1'b1);
    put_char(8'h78, 1'b0);
    put_char(8'hff, 1'b0);
    put_char(8'h71, 1'b0);
    put_char(8'h00, 1'b1);
    put_char(8'h00, 1'b0);
    put_char(8'h62, 1'b0);
    settle();
    // start state accepting, but only after a character can it count
    write_reg(REG_ACCEPT_STATE, 0);
    put_char(8'h7a, 1'b1);
    settle();
    write_reg(REG_TRANS_COUNT, 256);
    write_reg(REG_ACCEPT_STATE, 63);
    put_char(8'h61, 1'b1);
    put_char(8'hff, 1'b0);
    settle();
    write_reg(REG_TRANS_COUNT, 511);
    put_char(8'h00, 1'b1);
    settle();

    // back-pressure: receiver holds off while the sender keeps offering
    for (i = 0; i < 4; i++) put_rand_entry(i, 4);
    settle();
    write_reg(REG_TRANS_COUNT, 4);
    write_reg(REG_ACCEPT_STATE, $urandom_range(0, 3));
    quiet    = 1'b1;
    hold_req = 1'b1;
    for (i = 0; i < 40; i++) put_char(pick_sym(), (i % 8) == 0);
    settle();
    quiet = 1'b0;

    total = 0;
    while (total < 100) begin
      n = $urandom_range(20, 50);
      random_phase(n);
      total += n;
    end

    repeat (50) @(negedge clk);
    if (fail_cnt == 0 && pend_cnt == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

`default_nettype wire
